// ===== rtl/core/sorted_list_free_slot_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted list engine assertion macros
// Shared assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_FREE_SLOT_ENGINE_DEFINES_SVH
`define SORTED_LIST_FREE_SLOT_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define SLFSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLFSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SLFSE_ASSERT_NOW(label, ante, cons, msg)
`define SLFSE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/slfse_pkg.sv =====
// ----------------------------------------------------------------------------
// slfse_pkg
// Types and codes shared by the sorted list engine modules.
// ----------------------------------------------------------------------------
package slfse_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [1:0] STS_DONE     = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         entry_count;
    logic               min_valid;
    logic signed [31:0] min_key;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               cmp;
    logic               scan;
    logic               ins;
    logic               del;
    logic signed [31:0] key;
  } cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic               vld;
    logic signed [31:0] key;
    logic               ins;
    logic               ge_c;
    logic               fnd;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_APPLY,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/core/slfse_cell.sv =====
// ----------------------------------------------------------------------------
// slfse_cell
// One slot of the sorted chain: holds a key, compares it against the request
// key, passes the found flag rightward and shifts with its neighbors.
// ----------------------------------------------------------------------------
module slfse_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  slfse_pkg::cmd_t  cmd,
  input  slfse_pkg::link_t left,
  input  slfse_pkg::link_t right,
  output slfse_pkg::link_t self
);

  logic               vld_r;
  logic signed [31:0] key_r;
  logic               ins_r;
  logic               ge_r;
  logic               hit_r;
  logic               fnd_r;
  logic               ge_c;

  assign ge_c = vld_r && ($signed(key_r) >= $signed(cmd.key));

  assign self.vld  = vld_r;
  assign self.key  = key_r;
  assign self.ins  = ins_r;
  assign self.ge_c = ge_c;
  assign self.fnd  = fnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ins_r <= 1'b0;
      ge_r  <= 1'b0;
      hit_r <= 1'b0;
      fnd_r <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        ins_r <= !vld_r || ge_c;
        ge_r  <= ge_c;
        // first key not below the request key, and equal to it
        hit_r <= ge_c && !left.ge_c && (key_r == cmd.key);
        fnd_r <= 1'b0;
      end
      if (cmd.scan) begin
        fnd_r <= left.fnd || hit_r;
      end
      if (cmd.ins && ins_r) begin
        vld_r <= left.ins ? left.vld : 1'b1;
      end
      if (cmd.del && ge_r) begin
        vld_r <= right.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && ins_r) begin
      key_r <= left.ins ? left.key : cmd.key;
    end else if (cmd.del && ge_r) begin
      key_r <= right.key;
    end
  end

endmodule

// ===== rtl/core/slfse_ctrl.sv =====
// ----------------------------------------------------------------------------
// slfse_ctrl
// Request sequencer: latch a request, compare, scan for a match (deletes only),
// apply the shift, then hand status and entry count to the result register.
// ----------------------------------------------------------------------------
`include "sorted_list_free_slot_engine_defines.svh"

module slfse_ctrl #(
  parameter int ENTRIES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slfse_pkg::req_t     in_data,
  input  logic                full,
  input  logic                found,
  input  logic                out_free,
  output slfse_pkg::cmd_t     cmd,
  output logic                load_out,
  output logic [1:0]          status,
  output logic [3:0]          count
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SCN_W = $clog2(ENTRIES);

  slfse_pkg::state_t st_r, st_nxt;
  slfse_pkg::req_t   req_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SCN_W-1:0]  scn_r, scn_nxt;
  logic [1:0]        sts_r, sts_nxt;
  logic [CNT_W+3:0]  cnt_ext;
  logic              last_scan;
  logic              accept;

  assign accept    = in_valid && in_ready;
  assign last_scan = (scn_r == SCN_W'(ENTRIES - 1));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      slfse_pkg::ST_IDLE:  if (in_valid) st_nxt = slfse_pkg::ST_CMP;
      slfse_pkg::ST_CMP: begin
        if (req_r.req_type == slfse_pkg::REQ_DELETE) st_nxt = slfse_pkg::ST_SCAN;
        else st_nxt = slfse_pkg::ST_APPLY;
      end
      slfse_pkg::ST_SCAN:  if (last_scan) st_nxt = slfse_pkg::ST_APPLY;
      slfse_pkg::ST_APPLY: st_nxt = slfse_pkg::ST_RESP;
      slfse_pkg::ST_RESP:  if (out_free) st_nxt = slfse_pkg::ST_IDLE;
      default:             st_nxt = slfse_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    cmd      = '0;
    cmd.key  = req_r.key;
    cnt_nxt  = cnt_r;
    scn_nxt  = scn_r;
    sts_nxt  = sts_r;
    case (st_r)
      slfse_pkg::ST_IDLE: in_ready = 1'b1;
      slfse_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        scn_nxt = '0;
      end
      slfse_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        scn_nxt  = scn_r + 1'b1;
      end
      slfse_pkg::ST_APPLY: begin
        if (req_r.req_type == slfse_pkg::REQ_INSERT) begin
          if (full) begin
            sts_nxt = slfse_pkg::STS_FULL;
          end else begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            sts_nxt = slfse_pkg::STS_DONE;
          end
        end else begin
          if (found) begin
            cmd.del = 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            sts_nxt = slfse_pkg::STS_DONE;
          end else begin
            sts_nxt = slfse_pkg::STS_NOTFOUND;
          end
        end
      end
      slfse_pkg::ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= slfse_pkg::ST_IDLE;
      cnt_r <= '0;
      scn_r <= '0;
      sts_r <= slfse_pkg::STS_DONE;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      scn_r <= scn_nxt;
      sts_r <= sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
  end

  assign cnt_ext = {4'b0000, cnt_r};
  assign count   = cnt_ext[3:0];
  assign status  = sts_r;

  `SLFSE_ASSERT_NEXT(a_accept_cmp, accept, st_r == slfse_pkg::ST_CMP, "accept must start compare")
  `SLFSE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(ENTRIES), "entry count above pool size")
  `SLFSE_ASSERT_NOW(a_ins_not_full, cmd.ins, !full, "insert applied to a full chain")
  `SLFSE_ASSERT_NEXT(a_resp_hold, (st_r == slfse_pkg::ST_RESP) && !out_free,
                     st_r == slfse_pkg::ST_RESP, "result dropped while output busy")

endmodule

// ===== rtl/core/sorted_list_free_slot_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_free_slot_engine
// Sorted signed-key store built as a chain of ENTRIES shifting cells.
// ----------------------------------------------------------------------------
// Inserts compare then apply; deletes also scan the chain while the found flag
//   ripples one cell per cycle. A request is taken only while the engine is idle.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, rst_n low) empties the chain at once; no clearing pass.
module sorted_list_free_slot_engine #(
  parameter int ENTRIES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  slfse_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output slfse_pkg::rsp_t out_data
);

  slfse_pkg::cmd_t  cmd;
  slfse_pkg::link_t lnk [ENTRIES];
  slfse_pkg::rsp_t  out_data_r;
  logic             out_valid_r;
  logic             out_free;
  logic             load_out;
  logic [1:0]       status;
  logic [3:0]       count;

  assign out_free = !out_valid_r || out_ready;

  slfse_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (lnk[ENTRIES-1].vld),
    .found    (lnk[ENTRIES-1].fnd),
    .out_free (out_free),
    .cmd      (cmd),
    .load_out (load_out),
    .status   (status),
    .count    (count)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    slfse_pkg::link_t left_l;
    slfse_pkg::link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = '0;
    end else begin : g_mid_l
      assign left_l = lnk[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_mid_r
      assign right_l = lnk[i+1];
    end
    slfse_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (left_l),
      .right (right_l),
      .self  (lnk[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // smallest key always sits in the first cell
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.status      <= status;
      out_data_r.entry_count <= count;
      out_data_r.min_valid   <= lnk[0].vld;
      out_data_r.min_key     <= lnk[0].vld ? lnk[0].key : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/tb_sorted_list_free_slot_engine.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_list_free_slot_engine
// Self-checking bench for the sorted key store. A directed table hits the key
// extremes, the full pool, duplicate keys, missed deletes and slot reuse. A
// random run of fill and drain phases follows. Every result beat is checked
// against the table's pinned result or a slot-pool model with its own free chain.
// ----------------------------------------------------------------------------
module tb_sorted_list_free_slot_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES   = 8;
  localparam int NIL       = ENTRIES;
  localparam int N_RAND    = 700;
  localparam int N_TAIL    = 120;
  localparam int LIMIT     = 400000;
  localparam int MAX_PRINT = 40;

  localparam logic signed [31:0] KMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KMIN = 32'sh8000_0000;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
    logic               pinned;
    logic [1:0]         st;
    logic [3:0]         cnt;
    logic               mv;
    logic signed [31:0] mkey;
  } row_t;

  localparam int N_DIR = 25;
  localparam row_t DIR_TAB [N_DIR] = '{
    '{slfse_pkg::REQ_DELETE, 32'sd5,  1'b1, slfse_pkg::STS_NOTFOUND, 4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, KMAX,    1'b1, slfse_pkg::STS_DONE,     4'd1, 1'b1, KMAX},
    '{slfse_pkg::REQ_INSERT, KMIN,    1'b1, slfse_pkg::STS_DONE,     4'd2, 1'b1, KMIN},
    '{slfse_pkg::REQ_INSERT, 32'sd0,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, -32'sd1, 1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, 32'sd1,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, 32'sd0,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, KMAX,    1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, KMIN,    1'b1, slfse_pkg::STS_DONE,     4'd8, 1'b1, KMIN},
    '{slfse_pkg::REQ_INSERT, 32'sd77, 1'b1, slfse_pkg::STS_FULL,     4'd8, 1'b1, KMIN},
    '{slfse_pkg::REQ_DELETE, 32'sd42, 1'b1, slfse_pkg::STS_NOTFOUND, 4'd8, 1'b1, KMIN},
    '{slfse_pkg::REQ_DELETE, KMIN,    1'b1, slfse_pkg::STS_DONE,     4'd7, 1'b1, KMIN},
    '{slfse_pkg::REQ_DELETE, KMIN,    1'b1, slfse_pkg::STS_DONE,     4'd6, 1'b1, -32'sd1},
    '{slfse_pkg::REQ_INSERT, -32'sd7, 1'b1, slfse_pkg::STS_DONE,     4'd7, 1'b1, -32'sd7},
    '{slfse_pkg::REQ_DELETE, KMAX,    1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, 32'sd0,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, -32'sd1, 1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, 32'sd0,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, KMAX,    1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, 32'sd1,  1'b0, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, -32'sd7, 1'b1, slfse_pkg::STS_DONE,     4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, -32'sd7, 1'b1, slfse_pkg::STS_NOTFOUND, 4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_INSERT, 32'sh5555_5555, 1'b0, slfse_pkg::STS_DONE, 4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, 32'shAAAA_AAAA, 1'b0, slfse_pkg::STS_DONE, 4'd0, 1'b0, 32'sd0},
    '{slfse_pkg::REQ_DELETE, 32'sh5555_5555, 1'b1, slfse_pkg::STS_DONE, 4'd0, 1'b0, 32'sd0}
  };

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  slfse_pkg::req_t in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  slfse_pkg::rsp_t out_data;

  // slot pool copy used for prediction
  logic signed [31:0] pool_key  [ENTRIES];
  int                 pool_next [ENTRIES];
  int                 free_next [ENTRIES];
  int                 list_first;
  int                 free_first;
  int unsigned        held;

  slfse_pkg::rsp_t rsp_q [$];
  slfse_pkg::rsp_t head_rsp;
  bit              tail_run = 1'b0;
  int unsigned     n_err, n_rsp, n_ins, n_del, n_full, n_miss, peak_held;
  int unsigned     cyc;

  sorted_list_free_slot_engine #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cyc, rsp_q.size());
      $display("sorted_list_free_slot_engine test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_err < MAX_PRINT)
      $display("mismatch beat %0d %s: got %0h expected %0h", n_rsp, what, got, want);
    n_err++;
  endtask

  function automatic void clear_pool();
    for (int i = 0; i < ENTRIES; i++) begin
      pool_key[i]  = '0;
      pool_next[i] = NIL;
      free_next[i] = (i + 1 < ENTRIES) ? i + 1 : NIL;
    end
    list_first = NIL;
    free_first = 0;
    held       = 0;
  endfunction

  function automatic slfse_pkg::rsp_t apply_req(input slfse_pkg::req_t r);
    logic signed [31:0] k;
    int                 slot, prv, cur, steps;
    slfse_pkg::rsp_t    res;
    k     = r.key;
    prv   = NIL;
    cur   = list_first;
    steps = 0;
    if (r.req_type == slfse_pkg::REQ_INSERT) begin
      n_ins++;
      if (free_first == NIL) begin
        res.status = slfse_pkg::STS_FULL;
        n_full++;
      end else begin
        slot           = free_first;
        free_first     = free_next[slot];
        pool_key[slot] = k;
        // stop at the first key not below k, so k lands ahead of equal keys
        while (cur != NIL && steps < ENTRIES && k > pool_key[cur]) begin
          prv = cur;
          cur = pool_next[cur];
          steps++;
        end
        pool_next[slot] = cur;
        if (prv != NIL) pool_next[prv] = slot;
        else list_first = slot;
        held++;
        res.status = slfse_pkg::STS_DONE;
      end
    end else begin
      n_del++;
      while (cur != NIL && steps < ENTRIES && pool_key[cur] != k) begin
        prv = cur;
        cur = pool_next[cur];
        steps++;
      end
      if (cur == NIL || steps >= ENTRIES) begin
        res.status = slfse_pkg::STS_NOTFOUND;
        n_miss++;
      end else begin
        if (prv != NIL) pool_next[prv] = pool_next[cur];
        else list_first = pool_next[cur];
        // freed slot goes to the head of the free chain
        free_next[cur] = free_first;
        free_first     = cur;
        if (held > 0) held--;
        res.status = slfse_pkg::STS_DONE;
      end
    end
    if (held > peak_held) peak_held = held;
    res.entry_count = held[3:0];
    res.min_valid   = (list_first != NIL);
    res.min_key     = (list_first != NIL) ? pool_key[list_first] : 32'sd0;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_key();
    int sel, pos, cur;
    sel = $urandom_range(0, 9);
    // reuse a held key so deletes hit and duplicates pile up
    if (sel inside {[5:6]} && held > 0) begin
      cur = list_first;
      pos = $urandom_range(0, held - 1);
      repeat (pos) cur = pool_next[cur];
      return pool_key[cur];
    end
    case (sel)
      0, 1, 2, 3: return int'($urandom_range(0, 7)) - 4;
      4: begin
        case ($urandom_range(0, 3))
          0:       return KMIN;
          1:       return KMAX;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input slfse_pkg::req_t r, input logic pinned,
                          input slfse_pkg::rsp_t want);
    slfse_pkg::rsp_t guess;
    if (!tail_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    guess = apply_req(r);
    rsp_q.push_back(pinned ? want : guess);
  endtask

  // result side: stall in random bursts, never in the tail
  initial begin
    forever begin
      if (!tail_run && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rsp_q.size() == 0) begin
        report_mismatch("result with none pending", 32'(out_data.status), '0);
      end else begin
        head_rsp = rsp_q.pop_front();
        if (out_data.status !== head_rsp.status)
          report_mismatch("status", 32'(out_data.status), 32'(head_rsp.status));
        if (out_data.entry_count !== head_rsp.entry_count)
          report_mismatch("entry_count", 32'(out_data.entry_count),
                          32'(head_rsp.entry_count));
        if (out_data.min_valid !== head_rsp.min_valid)
          report_mismatch("min_valid", 32'(out_data.min_valid), 32'(head_rsp.min_valid));
        if (out_data.min_key !== head_rsp.min_key)
          report_mismatch("min_key", out_data.min_key, head_rsp.min_key);
      end
      n_rsp++;
    end
  end

  initial begin
    slfse_pkg::req_t r;
    slfse_pkg::rsp_t want;
    bit              fill;
    clear_pool();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      r.req_type       = DIR_TAB[i].req_type;
      r.key            = DIR_TAB[i].key;
      want.status      = DIR_TAB[i].st;
      want.entry_count = DIR_TAB[i].cnt;
      want.min_valid   = DIR_TAB[i].mv;
      want.min_key     = DIR_TAB[i].mkey;
      send_req(r, DIR_TAB[i].pinned, want);
    end

    // alternate fill and drain phases so the pool swings between full and empty
    for (int i = 0; i < N_RAND; i++) begin
      fill       = ((i / 40) % 2) == 0;
      r.req_type = ($urandom_range(0, 99) < (fill ? 75 : 25)) ?
                   slfse_pkg::REQ_INSERT : slfse_pkg::REQ_DELETE;
      r.key      = pick_key();
      tail_run   = (i >= N_RAND - N_TAIL);
      send_req(r, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (rsp_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 12) @(posedge clk);

    $display("%0d inserts (%0d dropped on a full pool), %0d deletes (%0d missed)",
             n_ins, n_full, n_del, n_miss);
    $display("%0d result beats checked, peak occupancy %0d of %0d, %0d mismatches",
             n_rsp, peak_held, ENTRIES, n_err);
    if (n_err == 0 && rsp_q.size() == 0) begin
      $display("sorted_list_free_slot_engine test passed");
    end else begin
      $display("sorted_list_free_slot_engine test failed");
    end
    $finish;
  end

endmodule
